### hw/rtl/udr_pkg.sv
package udr_pkg;

  localparam int unsigned CfgWidth = 31;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned StepWidth = 66;
  localparam int unsigned CapBits = 59;

  localparam logic [31:0] RPM_K = 32'd2563369783;
  localparam int unsigned RpmShift = 29;

  typedef enum logic [1:0] {
    REG_TRACK_WIDTH  = 2'd0,
    REG_WHEEL_RADIUS = 2'd1,
    REG_MAX_RPM      = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                 ge;
    logic [StepWidth-1:0] diff;
  } cmp_result_t;

endpackage

### hw/rtl/udr_cmpsub.sv
module udr_cmpsub (
  input  logic [udr_pkg::StepWidth-1:0] a,
  input  logic [udr_pkg::StepWidth-1:0] b,
  output udr_pkg::cmp_result_t          result
);
  import udr_pkg::*;

  always_comb begin
    result.ge   = (a >= b);
    result.diff = a - b;
  end

endmodule

### hw/rtl/unicycle_to_differential_rpm.sv
// One shared compare-subtract unit does every square-root, division and scaling step
// one bit a cycle, and a 32x32 multiplier is shared; the scaling divisions run only
// when a wheel speed exceeds the RPM limit.
// Throughput: one item at a time; the next item is accepted once the result is registered.
// Reset: rst is synchronous and active high, clears control state and restores the
// default track width, wheel radius and RPM limit.
module unicycle_to_differential_rpm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [udr_pkg::CfgWidth-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [udr_pkg::DataWidth-1:0] vel_x,
  input  logic signed [udr_pkg::DataWidth-1:0] vel_y,
  input  logic signed [udr_pkg::DataWidth-1:0] omega,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [udr_pkg::DataWidth-1:0] left_rpm,
  output logic signed [udr_pkg::DataWidth-1:0] right_rpm,
  output logic                               limited
);
  import udr_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SQX   = 16'h0002,
    S_SQY   = 16'h0004,
    S_SQRT  = 16'h0008,
    S_LW    = 16'h0010,
    S_NUM   = 16'h0020,
    S_ABS   = 16'h0040,
    S_MLO   = 16'h0080,
    S_MHI   = 16'h0100,
    S_WDIV  = 16'h0200,
    S_CMP   = 16'h0400,
    S_KNUM  = 16'h0800,
    S_KDIV  = 16'h1000,
    S_SLOAD = 16'h2000,
    S_SDIV  = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  state_t state;
  logic [6:0] cnt;
  logic sel;
  logic [CfgWidth-1:0] track_width, wheel_radius, max_rpm;
  logic [31:0] ax, ay, aw;
  logic vneg, wneg;
  logic [63:0] acc;
  logic [StepWidth-1:0] dvd, rem, quo;
  logic [63:0] dvs;
  logic [62:0] lw;
  logic [64:0] nl, nr;
  logic [63:0] mag [2];
  logic neg [2];
  logic [63:0] plo;
  logic [63:0] kq;
  logic lim;

  logic [CfgWidth-1:0] r_eff, m_eff;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic sq;
  logic [StepWidth-1:0] cs_a, cs_b, rem_step, quo_step, dvd_step;
  cmp_result_t cs;
  logic [64:0] sv, sv_s, slw;
  logic [64:0] nl_abs, nr_abs;
  logic [94:0] pw;
  logic [63:0] big;
  logic [63:0] num;
  logic [63:0] mag10;
  logic load_out;

  function automatic logic [31:0] to_out(input logic n, input logic [63:0] m);
    logic [31:0] r;
    if (n) begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
      r = 32'd0 - r;
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  assign r_eff = (wheel_radius == '0) ? CfgWidth'(1) : wheel_radius;
  assign m_eff = (max_rpm == '0) ? CfgWidth'(1) : max_rpm;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    unique case (state)
      S_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_LW: begin
        mul_a = {1'b0, track_width};
        mul_b = aw;
      end
      S_MLO: begin
        mul_a = mag[sel][31:0];
        mul_b = RPM_K;
      end
      S_MHI: begin
        mul_a = {1'b0, mag[sel][62:32]};
        mul_b = RPM_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign sq = (state == S_SQRT);

  always_comb begin
    if (sq) begin
      cs_a = {rem[63:0], dvd[65:64]};
      cs_b = {quo[63:0], 2'b01};
    end else begin
      cs_a = {rem[64:0], dvd[65]};
      cs_b = {2'b00, dvs};
    end
  end

  udr_cmpsub u_cmpsub (
    .a      (cs_a),
    .b      (cs_b),
    .result (cs)
  );

  assign rem_step = cs.ge ? cs.diff : cs_a;
  assign quo_step = {quo[64:0], cs.ge};
  assign dvd_step = sq ? {dvd[63:0], 2'b00} : {dvd[64:0], 1'b0};

  assign sv = {16'd0, quo[31:0], 17'd0};
  assign sv_s = vneg ? (65'd0 - sv) : sv;
  assign slw = wneg ? (65'd0 - {2'b00, lw}) : {2'b00, lw};
  assign nl_abs = nl[64] ? (65'd0 - nl) : nl;
  assign nr_abs = nr[64] ? (65'd0 - nr) : nr;
  assign pw = {31'd0, plo} + {prod[62:0], 32'd0};
  assign big = (mag[0] >= mag[1]) ? mag[0] : mag[1];
  assign num = {kq[60:0], 3'b000} + {kq[62:0], 1'b0} + {33'd0, m_eff} - 64'd1;
  assign mag10 = {mag[sel][60:0], 3'b000} + {mag[sel][62:0], 1'b0};
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      track_width  <= CfgWidth'(32768);
      wheel_radius <= CfgWidth'(3277);
      max_rpm      <= CfgWidth'(19660800);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TRACK_WIDTH:  track_width  <= cfg_data;
        REG_WHEEL_RADIUS: wheel_radius <= cfg_data;
        REG_MAX_RPM:      max_rpm      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      sel       <= 1'b0;
      lim       <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        left_rpm  <= to_out(neg[0], mag[0]);
        right_rpm <= to_out(neg[1], mag[1]);
        limited   <= lim;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ax    <= vel_x[31] ? (32'd0 - vel_x) : vel_x;
            ay    <= vel_y[31] ? (32'd0 - vel_y) : vel_y;
            aw    <= omega[31] ? (32'd0 - omega) : omega;
            vneg  <= vel_y[31];
            wneg  <= omega[31];
            state <= S_SQX;
          end
        end
        S_SQX: begin
          acc   <= prod;
          state <= S_SQY;
        end
        S_SQY: begin
          dvd   <= {acc + prod, 2'b00};
          rem   <= '0;
          quo   <= '0;
          cnt   <= 7'd31;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rem <= rem_step;
          quo <= quo_step;
          dvd <= dvd_step;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            state <= S_LW;
          end
        end
        S_LW: begin
          lw    <= prod[62:0];
          state <= S_NUM;
        end
        S_NUM: begin
          nl    <= sv_s - slw;
          nr    <= sv_s + slw;
          state <= S_ABS;
        end
        S_ABS: begin
          neg[0] <= nl[64];
          neg[1] <= nr[64];
          mag[0] <= nl_abs[63:0];
          mag[1] <= nr_abs[63:0];
          sel    <= 1'b0;
          state  <= S_MLO;
        end
        S_MLO: begin
          plo   <= prod;
          state <= S_MHI;
        end
        S_MHI: begin
          dvd   <= pw[94:RpmShift];
          rem   <= '0;
          quo   <= '0;
          dvs   <= {33'd0, r_eff};
          cnt   <= 7'd65;
          state <= S_WDIV;
        end
        S_WDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          dvd <= dvd_step;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            mag[sel] <= (|quo_step[65:CapBits]) ? {5'd0, {CapBits{1'b1}}}
                                                : {5'd0, quo_step[CapBits-1:0]};
            if (sel == 1'b0) begin
              sel   <= 1'b1;
              state <= S_MLO;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (big > {33'd0, m_eff}) begin
            kq    <= big - {33'd0, m_eff};
            lim   <= 1'b1;
            state <= S_KNUM;
          end else begin
            lim   <= 1'b0;
            state <= S_DONE;
          end
        end
        S_KNUM: begin
          dvd   <= {num, 2'b00};
          rem   <= '0;
          quo   <= '0;
          dvs   <= {33'd0, m_eff};
          cnt   <= 7'd63;
          state <= S_KDIV;
        end
        S_KDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          dvd <= dvd_step;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            kq    <= quo_step[63:0];
            sel   <= 1'b0;
            state <= S_SLOAD;
          end
        end
        S_SLOAD: begin
          dvd   <= {mag10, 2'b00};
          rem   <= '0;
          quo   <= '0;
          dvs   <= kq + 64'd10;
          cnt   <= 7'd63;
          state <= S_SDIV;
        end
        S_SDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          dvd <= dvd_step;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            mag[sel] <= quo_step[63:0];
            if (sel == 1'b0) begin
              sel   <= 1'b1;
              state <= S_SLOAD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_limit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && lim |-> (mag[0] <= {33'd0, m_eff}) && (mag[1] <= {33'd0, m_eff}))
    else $error("scaled wheel speed exceeds the limit");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_WDIV || state == S_KDIV || state == S_SDIV) |-> (rem < {2'b00, dvs}))
    else $error("division remainder not below divisor");

  a_sqrt_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) && (cnt != '0) |=> (state == S_SQRT))
    else $error("square root left early");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (state == S_IDLE) && out_valid)
    else $error("result not registered on completion");

endmodule
